/* src/sli_pkg.sv */
// shared constants and types for the sorted insertion table
// used by sli_cell and sorted_list_insert_delete_top, no dependencies
package sli_pkg;

   localparam int CAPACITY      = 16;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int DATA_W        = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   typedef logic [1:0] cell_op_type;

   localparam cell_op_type OP_HOLD   = 2'd0;
   localparam cell_op_type OP_INSERT = 2'd1;
   localparam cell_op_type OP_DELETE = 2'd2;
   localparam cell_op_type OP_ROTATE = 2'd3;

   // broadcast to every cell
   typedef struct packed {
      cell_op_type       op;
      logic [DATA_W-1:0] key;
   } cell_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic [DATA_W-1:0] entry;
      logic              valid;
      logic              gt;
      logic              seen;
   } cell_link_type;

endpackage

/* src/sli_cell.sv */
// one slot of the sorted chain: holds an entry and its valid bit
// depends on sli_pkg
module sli_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  is_first,
   input  sli_pkg::cell_ctrl_type ctrl,
   input  sli_pkg::cell_link_type left_link,
   input  sli_pkg::cell_link_type right_link,
   input  logic [sli_pkg::DATA_W-1:0] head_entry,
   output sli_pkg::cell_link_type link_out
);
   import sli_pkg::*;

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              valid_ff, valid_in;
   logic              gt, seen;

   assign gt   = valid_ff && ($signed(entry_ff) > $signed(ctrl.key));
   // seen ripples to the right from the first matching entry
   assign seen = left_link.seen | (valid_ff && (entry_ff == ctrl.key));

   assign link_out.entry = entry_ff;
   assign link_out.valid = valid_ff;
   assign link_out.gt    = gt;
   assign link_out.seen  = seen;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (!valid_ff || gt) begin
               // shift right behind greater entries, the key lands at the boundary
               if (left_link.valid && left_link.gt) begin
                  entry_in = left_link.entry;
               end else begin
                  entry_in = ctrl.key;
               end
               valid_in = valid_ff | left_link.valid | is_first;
            end
         end
         OP_DELETE: begin
            if (seen) begin
               entry_in = right_link.entry;
               valid_in = right_link.valid;
            end
         end
         OP_ROTATE: begin
            if (valid_ff) begin
               entry_in = right_link.valid ? right_link.entry : head_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

/* src/sorted_list_insert_delete_top.sv */
// sorted insertion table: chain of sli_cell slots and the command sequencer
// depends on sli_pkg and sli_cell
//
// Keeps up to CAPACITY signed 32-bit entries in ascending order in a row of
// cells. A transaction is taken when start is high and busy is low. Results
// appear one per cycle on rsp_* with rsp_strobe high for a single cycle and
// cannot be held off. On insert all cells compare and shift at once. Delete
// removes every matching entry, one matching entry leaving the chain per
// cycle; a miss or an empty table gives its result without entering the
// delete state. Listing rotates the chain and shows cell 0 each cycle,
// leaving the order unchanged when done.
module sorted_list_insert_delete_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sli_pkg::CMD_W-1:0]          req_command,
   input  logic signed [sli_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_strobe,
   output logic signed [sli_pkg::DATA_W-1:0]  rsp_element,
   output logic [sli_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sli_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count,
   output logic                               rsp_last
);
   import sli_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DELETE = 2'd1;
   localparam logic [1:0] ST_LIST   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [DATA_W-1:0] key_ff, key_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0]   rsp_element_ff, rsp_element_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   cell_link_type links [CAPACITY];
   cell_link_type left_links [CAPACITY];
   cell_link_type right_links [CAPACITY];
   logic          accept;
   logic          any_match;
   logic          is_full;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign left_links[i] = '0;
         end else begin : g_mid
            assign left_links[i] = links[i-1];
         end
         if (i == CAPACITY - 1) begin : g_tail
            assign right_links[i] = '0;
         end else begin : g_body
            assign right_links[i] = links[i+1];
         end
         sli_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .is_first   (i == 0),
            .ctrl       (ctrl),
            .left_link  (left_links[i]),
            .right_link (right_links[i]),
            .head_entry (links[0].entry),
            .link_out   (links[i])
         );
      end
   endgenerate

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign any_match = links[CAPACITY-1].seen;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      key_in         = key_ff;
      ctrl.op        = OP_HOLD;
      ctrl.key       = (state_ff == ST_IDLE) ? req_value : key_ff;
      rsp_strobe_in  = 1'b0;
      rsp_element_in = '0;
      rsp_status_in  = STATUS_OK;
      rsp_count_in   = count_ff;
      rsp_last_in    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_value;
               case (req_command)
                  CMD_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctrl.op      = OP_INSERT;
                        count_in     = count_ff + CNT_W'(1);
                        rsp_count_in = count_in;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else if (!any_match) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_NOT_FOUND;
                     end else begin
                        // first removal happens on the accepting edge
                        ctrl.op  = OP_DELETE;
                        count_in = count_ff - CNT_W'(1);
                        state_in = ST_DELETE;
                     end
                  end
                  CMD_LIST: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        remain_in = count_ff;
                        state_in  = ST_LIST;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DELETE: begin
            if (any_match) begin
               ctrl.op  = OP_DELETE;
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_LIST: begin
            ctrl.op        = OP_ROTATE;
            rsp_strobe_in  = 1'b1;
            rsp_element_in = links[0].entry;
            rsp_last_in    = (remain_ff == CNT_W'(1));
            remain_in      = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      remain_ff      <= remain_in;
      rsp_element_ff <= rsp_element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = ENTRY_COUNT_W'(rsp_count_ff);
   assign rsp_last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_list_streams: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LIST |=> rsp_strobe)
      else $error("listing cycle without a result");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_INSERT && !is_full |=>
         count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the table");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STATUS_FULL |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status while table has room");

endmodule
